/* rtl/template_marker_segmenter_unit_defines.svh */
// ----------------------------------------------------------------------------
// template marker segmenter assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef TEMPLATE_MARKER_SEGMENTER_UNIT_DEFINES_SVH
`define TEMPLATE_MARKER_SEGMENTER_UNIT_DEFINES_SVH

// same-cycle implication
`define TMS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/tmseg_pkg.sv */
// ----------------------------------------------------------------------------
// template marker segmenter package
// shared widths, byte codes, status codes and transfer types
// ----------------------------------------------------------------------------
package tmseg_pkg;

	localparam int POS_BITS  = 16;
	localparam int DEPTH_MAX = 255;
	localparam int DEPTH_W   = $clog2(DEPTH_MAX + 1);
	localparam int MAX_RES   = 6;
	localparam int RES_IDX_W = $clog2(MAX_RES + 1);

	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_EQ    = 8'h3D;

	typedef enum logic [2:0] {
		ST_DATA      = 3'd0,
		ST_END_OK    = 3'd1,
		ST_UNMATCHED = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_OVERFLOW  = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_template;
	} in_item_t;

	typedef struct packed {
		logic [7:0]          out_byte;
		logic                byte_valid;
		logic                is_expression;
		logic                segment_first;
		logic [POS_BITS-1:0] position;
		status_t             status;
		logic                last_result;
	} out_item_t;

	// all results caused by one input byte
	typedef struct packed {
		out_item_t [MAX_RES-1:0] items;
		logic [RES_IDX_W-1:0]    count;
	} res_list_t;

endpackage

/* rtl/tmseg_scan.sv */
// ----------------------------------------------------------------------------
// template marker segmenter scanner
// scan state and the single-pass decode of one byte into its results
// ----------------------------------------------------------------------------
module tmseg_scan (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tmseg_pkg::in_item_t  item,
	input  logic                 advance,
	output tmseg_pkg::res_list_t results
);
	import tmseg_pkg::*;

	typedef enum logic [1:0] {
		MODE_LIT,
		MODE_EXPR,
		MODE_ERR
	} mode_t;

	mode_t               mode_q, mode_d;
	logic [2:0][7:0]     held_q, held_d;
	logic [1:0]          held_cnt_q, held_cnt_d;
	logic [POS_BITS-1:0] pos_q, pos_d;
	logic                lit_open_q, lit_open_d;
	logic [POS_BITS-1:0] lit_start_q, lit_start_d;
	logic [POS_BITS-1:0] marker_q, marker_d;
	logic [DEPTH_W-1:0]  depth_q, depth_d;
	logic                empty_q, empty_d;

	function automatic out_item_t make_item(logic [7:0] b, logic vld, logic expr,
			logic first, logic [POS_BITS-1:0] pos, status_t st);
		out_item_t r;
		r.out_byte      = b;
		r.byte_valid    = vld;
		r.is_expression = expr;
		r.segment_first = first;
		r.position      = pos;
		r.status        = st;
		r.last_result   = 1'b0;
		return r;
	endfunction

	always_comb begin
		out_item_t [MAX_RES-1:0] res;
		logic [RES_IDX_W-1:0]    n;
		logic [0:6][7:0]         w;
		logic [2:0]              len;
		logic [2:0]              idx;
		logic [2:0]              rem;
		logic                    stop;
		logic                    restart;
		logic [POS_BITS-1:0]     p0;
		logic [POS_BITS-1:0]     here;
		logic [7:0]              s0, s1, s2, s3;
		logic [1:0]              lit_k;
		logic [0:2][7:0]         lit_b;
		logic                    first;
		logic                    fin;
		logic                    p_bsl, p_esc, p_open;

		res      = '0;
		n        = '0;
		w        = '0;
		len      = '0;
		idx      = '0;
		rem      = '0;
		stop     = 1'b0;
		restart  = 1'b0;
		p0       = '0;
		here     = '0;
		s0       = '0;
		s1       = '0;
		s2       = '0;
		s3       = '0;
		lit_k    = '0;
		lit_b    = '0;
		first    = 1'b0;
		p_bsl    = 1'b0;
		p_esc    = 1'b0;
		p_open   = 1'b0;
		fin      = item.end_of_template;

		mode_d      = mode_q;
		held_d      = held_q;
		held_cnt_d  = held_cnt_q;
		pos_d       = pos_q;
		lit_open_d  = lit_open_q;
		lit_start_d = lit_start_q;
		marker_d    = marker_q;
		depth_d     = depth_q;
		empty_d     = empty_q;

		if (mode_q == MODE_ERR) begin
			// skip to end of template
			restart = fin;
		end else begin
			// window: held bytes then the new byte
			for (int k = 0; k < 3; k++) begin
				if (k < int'(held_cnt_q)) begin
					w[k] = held_q[k];
				end
			end
			w[{1'b0, held_cnt_q}] = item.in_byte;
			len        = {1'b0, held_cnt_q} + 3'd1;
			p0         = pos_q - POS_BITS'(held_cnt_q);
			held_cnt_d = '0;

			for (int it = 0; it < 4; it++) begin
				if (!stop && idx < len) begin
					rem   = len - idx;
					here  = p0 + POS_BITS'(idx);
					s0    = w[idx];
					s1    = w[idx + 3'd1];
					s2    = w[idx + 3'd2];
					s3    = w[idx + 3'd3];
					lit_k = '0;
					p_bsl  = (rem <= 3'd2) && (s0 == CH_BSL) &&
						((rem < 3'd2) || (s1 == CH_BSL));
					p_esc  = (s0 == CH_BSL) && ((rem < 3'd2) || (s1 == CH_LPAR)) &&
						((rem < 3'd3) || (s2 == CH_QMARK));
					p_open = (s0 == CH_LPAR) && ((rem < 3'd2) || (s1 == CH_QMARK)) &&
						((rem < 3'd3) || (s2 == CH_EQ));

					if (mode_d == MODE_ERR) begin
						stop = 1'b1;
					end else if (mode_d == MODE_EXPR) begin
						idx = idx + 3'd1;
						if (s0 == CH_LPAR) begin
							if (depth_d >= DEPTH_W'(DEPTH_MAX)) begin
								if (n < RES_IDX_W'(MAX_RES)) begin
									res[n] = make_item('0, 1'b0, 1'b0, 1'b0, marker_d,
										ST_OVERFLOW);
									n = n + 1'b1;
								end
								mode_d = MODE_ERR;
							end else begin
								depth_d = depth_d + 1'b1;
								if (n < RES_IDX_W'(MAX_RES)) begin
									res[n] = make_item(s0, 1'b1, 1'b1, empty_d, marker_d,
										ST_DATA);
									n = n + 1'b1;
								end
								empty_d = 1'b0;
							end
						end else if (s0 == CH_RPAR && depth_d <= DEPTH_W'(1)) begin
							if (empty_d) begin
								if (n < RES_IDX_W'(MAX_RES)) begin
									res[n] = make_item('0, 1'b0, 1'b0, 1'b0, marker_d,
										ST_EMPTY);
									n = n + 1'b1;
								end
								mode_d = MODE_ERR;
							end else begin
								// closing paren ends the expression, not emitted
								depth_d = '0;
								mode_d  = MODE_LIT;
							end
						end else begin
							if (s0 == CH_RPAR) begin
								depth_d = depth_d - 1'b1;
							end
							if (n < RES_IDX_W'(MAX_RES)) begin
								res[n] = make_item(s0, 1'b1, 1'b1, empty_d, marker_d, ST_DATA);
								n = n + 1'b1;
							end
							empty_d = 1'b0;
						end
					end else if (rem >= 3'd2 && s0 == CH_BSL && s1 == CH_BSL) begin
						lit_k    = 2'd1;
						lit_b[0] = CH_BSL;
						idx      = idx + 3'd2;
					end else if (rem >= 3'd4 && s0 == CH_BSL && s1 == CH_LPAR &&
							s2 == CH_QMARK && s3 == CH_EQ) begin
						lit_k = 2'd3;
						lit_b = {CH_LPAR, CH_QMARK, CH_EQ};
						idx   = idx + 3'd4;
					end else if (rem >= 3'd3 && s0 == CH_LPAR && s1 == CH_QMARK &&
							s2 == CH_EQ) begin
						lit_open_d = 1'b0;
						mode_d     = MODE_EXPR;
						marker_d   = here;
						depth_d    = DEPTH_W'(1);
						empty_d    = 1'b1;
						idx        = idx + 3'd3;
					end else if (!fin && rem <= 3'd3 && (p_bsl || p_esc || p_open)) begin
						// undecided tail, keep for the next byte
						held_d     = {s2, s1, s0};
						held_cnt_d = rem[1:0];
						stop       = 1'b1;
					end else begin
						lit_k    = 2'd1;
						lit_b[0] = s0;
						idx      = idx + 3'd1;
					end

					for (int j = 0; j < 3; j++) begin
						if (j < int'(lit_k)) begin
							first = !lit_open_d;
							if (!lit_open_d) begin
								lit_open_d  = 1'b1;
								lit_start_d = here;
							end
							if (n < RES_IDX_W'(MAX_RES)) begin
								res[n] = make_item(lit_b[j], 1'b1, 1'b0, first, lit_start_d,
									ST_DATA);
								n = n + 1'b1;
							end
						end
					end
				end
			end

			pos_d = pos_q + 1'b1;

			if (fin) begin
				restart = 1'b1;
				if (mode_d != MODE_ERR && n < RES_IDX_W'(MAX_RES)) begin
					if (mode_d == MODE_LIT) begin
						res[n] = make_item('0, 1'b0, 1'b0, 1'b0, '0, ST_END_OK);
					end else begin
						res[n] = make_item('0, 1'b0, 1'b0, 1'b0, marker_d, ST_UNMATCHED);
					end
					n = n + 1'b1;
				end
			end
		end

		if (restart) begin
			mode_d      = MODE_LIT;
			held_cnt_d  = '0;
			pos_d       = '0;
			lit_open_d  = 1'b0;
			lit_start_d = '0;
			marker_d    = '0;
			depth_d     = '0;
			empty_d     = 1'b1;
		end

		if (n != '0) begin
			res[n - 1'b1].last_result = 1'b1;
		end

		results.items = res;
		results.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_LIT;
			held_cnt_q  <= '0;
			pos_q       <= '0;
			lit_open_q  <= 1'b0;
			lit_start_q <= '0;
			marker_q    <= '0;
			depth_q     <= '0;
			empty_q     <= 1'b1;
		end else if (advance) begin
			mode_q      <= mode_d;
			held_cnt_q  <= held_cnt_d;
			pos_q       <= pos_d;
			lit_open_q  <= lit_open_d;
			lit_start_q <= lit_start_d;
			marker_q    <= marker_d;
			depth_q     <= depth_d;
			empty_q     <= empty_d;
		end
	end

	// held bytes are only read below the held count
	always_ff @(posedge clk) begin
		if (advance) begin
			held_q <= held_d;
		end
	end

endmodule

/* rtl/tmseg_outbuf.sv */
// ----------------------------------------------------------------------------
// template marker segmenter result buffer
// holds the results of one byte and hands them out one per transfer
// ----------------------------------------------------------------------------
module tmseg_outbuf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  tmseg_pkg::res_list_t results,
	output logic                 free,
	output logic                 out_valid,
	input  logic                 out_ready,
	output tmseg_pkg::out_item_t out_data
);
	import tmseg_pkg::*;

	out_item_t [MAX_RES-1:0] res_s2;
	logic [RES_IDX_W-1:0]    cnt_s2;
	logic [RES_IDX_W-1:0]    rd_q;

	assign out_valid = (rd_q != cnt_s2);
	// empty now, or the last entry leaves this cycle
	assign free = !out_valid || (out_ready && (rd_q + 1'b1 == cnt_s2));

	always_comb begin
		out_data = '0;
		if (rd_q < RES_IDX_W'(MAX_RES)) begin
			out_data = res_s2[rd_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= '0;
			rd_q   <= '0;
		end else if (load) begin
			cnt_s2 <= results.count;
			rd_q   <= '0;
		end else if (out_valid && out_ready) begin
			rd_q <= rd_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= results.items;
		end
	end

endmodule

/* rtl/template_marker_segmenter_unit.sv */
// ----------------------------------------------------------------------------
// template marker segmenter unit
// splits a template byte stream into literal and expression segments
// ----------------------------------------------------------------------------
// Takes one template byte per transfer and returns its results one per output
// transfer. Outside an expression a double backslash decodes to one backslash,
// backslash-paren-question-equals decodes to the literal text "(?=", and
// "(?=" opens an expression; up to three undecided bytes are held and flushed
// as literals when a partial match fails. Expression bytes pass raw with a
// parenthesis depth count until the matching ")" which is dropped. Each
// result carries the byte, its literal or expression tag, a first-of-segment
// flag, the segment start position and a status; the byte flagged
// end_of_template adds an end status unless an error came first. An empty
// expression, a depth overflow or an open expression at end of template
// reports an error with the marker position; later bytes are dropped up to
// the end of the template. Rate: an input byte is taken every cycle as long
// as each byte causes at most one result and the output is not stalled; a
// byte causing several results holds back the next byte until its last
// result leaves, since the result buffer hands out one result per cycle.
// An input byte passes the input register and the result buffer in turn.
// ----------------------------------------------------------------------------
module template_marker_segmenter_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  tmseg_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output tmseg_pkg::out_item_t out_data
);
	import tmseg_pkg::*;

	// input register
	in_item_t  in_s1;
	logic      valid_s1;

	// decode results and buffer handshake
	res_list_t results;
	logic      buf_free;
	logic      advance;

	// the byte in the input register is decoded as it moves into the buffer
	assign advance  = valid_s1 && buf_free;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			in_s1 <= in_data;
		end
	end

	// scan state lives here and steps once per decoded byte
	tmseg_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (in_s1),
		.advance (advance),
		.results (results)
	);

	// output side, one result per transfer
	tmseg_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.results   (results),
		.free      (buf_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

/* rtl/tmseg_checker.sv */
// ----------------------------------------------------------------------------
// template marker segmenter port checker
// port-level properties of the result stream, bound to the top level
// ----------------------------------------------------------------------------
`include "template_marker_segmenter_unit_defines.svh"

module tmseg_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input tmseg_pkg::in_item_t  in_data,
	input logic                 out_valid,
	input logic                 out_ready,
	input tmseg_pkg::out_item_t out_data
);
	import tmseg_pkg::*;

	// a status result always closes the results of its byte
	`TMS_ASSERT_NOW(a_status_last, clk, arst_n, out_valid && !out_data.byte_valid, out_data.last_result, "status result not last")

	// status-only results carry no segment text or tags
	`TMS_ASSERT_NOW(a_status_clean, clk, arst_n, out_valid && !out_data.byte_valid, !out_data.is_expression && !out_data.segment_first && out_data.out_byte == 8'd0 && out_data.status != ST_DATA, "status result has segment fields")

	// more results of the same byte follow right away
	`TMS_ASSERT_NEXT(a_burst_cont, clk, arst_n, out_valid && out_ready && !out_data.last_result, out_valid, "gap inside a result burst")

	// a stalled result holds
	`TMS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

	// a waiting input byte holds
	`TMS_ASSERT_NEXT(a_in_hold, clk, arst_n, in_valid && !in_ready, in_valid && $stable(in_data), "input changed")

endmodule

bind template_marker_segmenter_unit tmseg_checker u_tmseg_checker (.*);
